// ----- rtl/core/lpe_pkg.sv -----
// Package: shared constants, types and the symbol encoder for the LED pixel encoder.
`default_nettype none
package lpe_pkg;

   localparam int WORD_WIDTH      = 16;
   localparam int COLOR_WIDTH     = 8;
   localparam int SYM_WIDTH       = 3;
   localparam int COLORS          = 3;
   localparam int PIXEL_BITS      = COLORS * COLOR_WIDTH;
   localparam int STREAM_WIDTH    = PIXEL_BITS * SYM_WIDTH;
   localparam int ACC_WIDTH       = STREAM_WIDTH + WORD_WIDTH;
   localparam int CNT_WIDTH       = $clog2(ACC_WIDTH);
   localparam int FILL_WIDTH      = $clog2(WORD_WIDTH);
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = SYM_WIDTH;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);

   localparam logic [SYM_WIDTH-1:0] ONE_SYMBOL_RESET  = 3'd6;
   localparam logic [SYM_WIDTH-1:0] ZERO_SYMBOL_RESET = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_SYMBOL  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_SYMBOL = 1'd1;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic                    flush;
      logic                    open_frame;
      logic [STREAM_WIDTH-1:0] stream;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_LAST
   } back_state_type;

   // Green MSB lands in the top symbol slot.
   function automatic logic [STREAM_WIDTH-1:0] encode_pixel(
      input logic [PIXEL_BITS-1:0] colors,
      input logic [SYM_WIDTH-1:0]  one_sym,
      input logic [SYM_WIDTH-1:0]  zero_sym
   );
      logic [STREAM_WIDTH-1:0] stream;
      stream = '0;
      for (int i = 0; i < PIXEL_BITS; i++) begin
         stream[SYM_WIDTH*i +: SYM_WIDTH] = colors[i] ? one_sym : zero_sym;
      end
      return stream;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lpe_if.sv -----
// Interfaces: pixel request channel and word response channel.
`default_nettype none
interface lpe_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [lpe_pkg::COLOR_WIDTH-1:0] green;
   logic [lpe_pkg::COLOR_WIDTH-1:0] red;
   logic [lpe_pkg::COLOR_WIDTH-1:0] blue;

   modport source(output valid, mode, green, red, blue, input ready);
   modport sink(input valid, mode, green, red, blue, output ready);
endinterface

interface lpe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lpe_pkg::WORD_WIDTH-1:0] word;
   logic                           last;

   modport source(output valid, word, last, input ready);
   modport sink(input valid, word, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lpe_front.sv -----
// Front end: symbol registers, item accept, frame tracking and symbol encoding.
`default_nettype none
module lpe_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lpe_req_if.sink                                   req,
   input  wire logic                                 csr_write_enable,
   input  wire logic [lpe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [lpe_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  wire logic                                 queue_full,
   output      logic                                 push,
   output      lpe_pkg::cmd_type                     cmd
);
   import lpe_pkg::*;

   logic [SYM_WIDTH-1:0] one_sym_ff, one_sym_in;
   logic [SYM_WIDTH-1:0] zero_sym_ff, zero_sym_in;
   logic                 frame_open_ff, frame_open_in;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      cmd.flush      = (req.mode == MODE_FLUSH);
      cmd.open_frame = (req.mode == MODE_PIXEL) && !frame_open_ff;
      cmd.stream     = encode_pixel({req.green, req.red, req.blue}, one_sym_ff, zero_sym_ff);
   end

   always_comb begin
      one_sym_in    = one_sym_ff;
      zero_sym_in   = zero_sym_ff;
      frame_open_in = frame_open_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ONE_SYMBOL:  one_sym_in  = csr_write_data;
            CSR_ZERO_SYMBOL: zero_sym_in = csr_write_data;
            default: ;
         endcase
      end
      if (push) begin
         frame_open_in = (req.mode == MODE_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_sym_ff    <= ONE_SYMBOL_RESET;
         zero_sym_ff   <= ZERO_SYMBOL_RESET;
         frame_open_ff <= 1'b0;
      end else begin
         one_sym_ff    <= one_sym_in;
         zero_sym_ff   <= zero_sym_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/lpe_queue.sv -----
// Command queue between front and back end.
`default_nettype none
module lpe_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lpe_pkg::cmd_type push_cmd,
   output      logic             full,
   input  wire logic             pop,
   output      logic             not_empty,
   output      lpe_pkg::cmd_type head
);
   import lpe_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_WIDTH:0]    count_ff, count_in;

   localparam logic [QPTR_WIDTH-1:0] LAST_SLOT = QPTR_WIDTH'(QUEUE_DEPTH - 1);

   assign full      = (count_ff == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/lpe_back.sv -----
// Back end: bit packer into 16-bit words and the response output register.
`default_nettype none
module lpe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire lpe_pkg::cmd_type cmd,
   output      logic             cmd_pop,
   lpe_rsp_if.source             rsp
);
   import lpe_pkg::*;

   back_state_type          state_ff, state_in;
   // Pending bits, left-justified; bits below the count are always zero.
   logic [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]   rsp_word_ff, rsp_word_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    can_emit;
   logic [ACC_WIDTH-1:0]    merged;
   logic [CNT_WIDTH-1:0]    cnt_less;

   localparam logic [CNT_WIDTH-1:0] WORD_BITS   = CNT_WIDTH'(WORD_WIDTH);
   localparam logic [CNT_WIDTH-1:0] STREAM_BITS = CNT_WIDTH'(STREAM_WIDTH);

   assign can_emit  = !rsp_valid_ff || rsp.ready;
   assign merged    = acc_ff | ({cmd.stream, WORD_WIDTH'(0)} >> cnt_ff[FILL_WIDTH-1:0]);
   assign cnt_less  = cnt_ff - WORD_BITS;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.word  = rsp_word_ff;
   assign rsp.last  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      cmd_pop      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && can_emit) begin
               cmd_pop      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (cmd.flush) begin
                  acc_in = '0;
                  cnt_in = '0;
                  if (cnt_ff != '0) begin
                     rsp_word_in = acc_ff[ACC_WIDTH-1 -: WORD_WIDTH];
                     state_in    = BK_LAST;
                  end else begin
                     rsp_word_in = '0;
                     rsp_last_in = 1'b1;
                  end
               end else if (cmd.open_frame) begin
                  rsp_word_in = '0;
                  acc_in      = merged;
                  cnt_in      = cnt_ff + STREAM_BITS;
                  state_in    = BK_RUN;
               end else begin
                  rsp_word_in = merged[ACC_WIDTH-1 -: WORD_WIDTH];
                  acc_in      = merged << WORD_WIDTH;
                  cnt_in      = cnt_ff + STREAM_BITS - WORD_BITS;
                  state_in    = BK_RUN;
               end
            end
         end
         BK_RUN: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_word_in  = acc_ff[ACC_WIDTH-1 -: WORD_WIDTH];
               acc_in       = acc_ff << WORD_WIDTH;
               cnt_in       = cnt_less;
               if (cnt_less < WORD_BITS) begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_LAST: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_word_in  = '0;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/led_pixel_spi_bit_encoder_top.sv -----
// Top level: LED pixel to three-bit line symbol encoder, 16-bit word output.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+---------------------------------------
//  req     | in  | valid / ready   | mode, green, red, blue
//  rsp     | out | valid / ready   | word (16b, first bit in bit 15), last
//  csr     | in  | write enable    | csr_index (0 one symbol, 1 zero symbol)
//
// One output word per cycle from the back-end packer while rsp is not stalled;
// a pixel emits one word per 16 bits of stream, plus the opening zero word
// of a frame, and a flush emits any partial word, then the last word.
// Synchronous active-high reset; symbols return to 110 / 100.
// A two-item queue lets the front take items while the packer or the rsp
// side is stalled; rsp is a registered output.
`default_nettype none
module led_pixel_spi_bit_encoder_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lpe_req_if.sink                                  req,
   lpe_rsp_if.source                                rsp,
   input  wire logic                                csr_write_enable,
   input  wire logic [lpe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [lpe_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import lpe_pkg::*;

   // front -> queue
   logic    push;
   logic    queue_full;
   cmd_type push_cmd;

   // queue -> back
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type head_cmd;

   // Encodes each pixel into its 72-bit symbol stream at accept time and
   // tags whether the frame's opening zero word is due.
   lpe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .cmd              (push_cmd)
   );

   lpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .head      (head_cmd)
   );

   // Merges the stream behind the leftover partial word and shifts out
   // one 16-bit word per cycle while the rsp side is not stalled.
   lpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

// ----- rtl/core/lpe_checker.sv -----
// Checker: port-level assertions for the LED pixel encoder, bound to the top.
`default_nettype none
module lpe_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [lpe_pkg::WORD_WIDTH-1:0] rsp_word,
   input wire logic                           rsp_last
);
   import lpe_pkg::*;

   // Stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_last))
      else $error("rsp item changed while stalled");

   // Frame trailer is always an all-zero word.
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_word == '0)
      else $error("last item carries a nonzero word");

   // Output register is empty right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind led_pixel_spi_bit_encoder_top lpe_checker u_lpe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_word  (rsp.word),
   .rsp_last  (rsp.last)
);
`default_nettype wire
